>>> rtl/jsu_pkg.sv
package jsu_pkg;

    // Decoder modes, one-hot
    typedef enum logic [6:0] {
        M_IDLE     = 7'b0000001,
        M_TEXT     = 7'b0000010,
        M_ESC      = 7'b0000100,
        M_HEX1     = 7'b0001000,
        M_HIGH     = 7'b0010000,
        M_HIGH_ESC = 7'b0100000,
        M_HEX2     = 7'b1000000
    } t_mode;

    typedef enum logic [2:0] {
        ST_DATA     = 3'd0,
        ST_CLOSE    = 3'd1,
        ST_BAD_ESC  = 3'd2,
        ST_BAD_HEX  = 3'd3,
        ST_BAD_PAIR = 3'd4,
        ST_UNTERM   = 3'd5
    } t_status;

    localparam int unsigned MAX_RES = 4;

    typedef struct packed {
        t_mode       mode;
        logic [15:0] hex_accum;
        logic [1:0]  hex_count;
        logic [9:0]  held;
    } t_dec_state;

    typedef struct packed {
        logic [7:0] out_byte;
        t_status    status;
        logic       last;
    } t_res;

    // Results caused by one input item; res[0] goes out first
    typedef struct packed {
        logic [2:0]             cnt;
        t_res [MAX_RES-1:0]     res;
    } t_group;

endpackage

>>> rtl/jsu_ifs.sv
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] raw_byte;
    logic       input_ends;

    modport source (output valid, output raw_byte, output input_ends, input ready);
    modport sink   (input valid, input raw_byte, input input_ends, output ready);
endinterface

interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output out_byte, output status, output last, input ready);
    modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

>>> rtl/jsu_decoder.sv
module jsu_decoder (
    input  jsu_pkg::t_dec_state i_state,
    input  logic [7:0]          i_raw_byte,
    input  logic                i_input_ends,
    output jsu_pkg::t_dec_state o_next_state,
    output jsu_pkg::t_group     o_group
);

    function automatic jsu_pkg::t_res data_res(input logic [7:0] b);
        jsu_pkg::t_res r;
        r.out_byte = b;
        r.status   = jsu_pkg::ST_DATA;
        r.last     = 1'b0;
        return r;
    endfunction

    function automatic jsu_pkg::t_res end_res(input jsu_pkg::t_status s);
        jsu_pkg::t_res r;
        r.out_byte = 8'h00;
        r.status   = s;
        r.last     = 1'b1;
        return r;
    endfunction

    function automatic jsu_pkg::t_group utf8(input logic [20:0] cp);
        jsu_pkg::t_group g;
        g = '0;
        if (cp < 21'h80) begin
            g.cnt    = 3'd1;
            g.res[0] = data_res(cp[7:0]);
        end else if (cp < 21'h800) begin
            g.cnt    = 3'd2;
            g.res[0] = data_res({3'b110, cp[10:6]});
            g.res[1] = data_res({2'b10, cp[5:0]});
        end else if (cp < 21'h10000) begin
            g.cnt    = 3'd3;
            g.res[0] = data_res({4'b1110, cp[15:12]});
            g.res[1] = data_res({2'b10, cp[11:6]});
            g.res[2] = data_res({2'b10, cp[5:0]});
        end else begin
            g.cnt    = 3'd4;
            g.res[0] = data_res({5'b11110, cp[20:18]});
            g.res[1] = data_res({2'b10, cp[17:12]});
            g.res[2] = data_res({2'b10, cp[11:6]});
            g.res[3] = data_res({2'b10, cp[5:0]});
        end
        return g;
    endfunction

    function automatic jsu_pkg::t_group one_res(input jsu_pkg::t_res r);
        jsu_pkg::t_group g;
        g        = '0;
        g.cnt    = 3'd1;
        g.res[0] = r;
        return g;
    endfunction

    logic [7:0]      b;
    logic            is_digit;
    logic            is_alpha;
    logic            hex_ok;
    logic [3:0]      hex_d;
    logic [15:0]     acc_new;
    logic [20:0]     pair_cp;
    jsu_pkg::t_group lone_grp;
    jsu_pkg::t_group text_grp;
    jsu_pkg::t_mode  text_mode;
    jsu_pkg::t_group esc_grp;
    jsu_pkg::t_mode  esc_mode;
    logic            esc_is_u;
    jsu_pkg::t_group main_grp;
    logic            lone;
    jsu_pkg::t_dec_state ns;

    assign b        = i_raw_byte;
    assign is_digit = (b >= 8'h30) && (b <= 8'h39);
    assign is_alpha = ((b >= 8'h61) && (b <= 8'h66)) || ((b >= 8'h41) && (b <= 8'h46));
    assign hex_ok   = is_digit || is_alpha;
    assign hex_d    = is_digit ? b[3:0] : (b[3:0] + 4'd9);
    assign acc_new  = {i_state.hex_accum[11:0], hex_d};
    // 0x10000 + (held << 10) + (lo - 0xDC00); low ten bits come straight from lo
    assign pair_cp  = {11'h040 + {1'b0, i_state.held}, acc_new[9:0]};
    assign lone_grp = utf8({5'd0, 16'hD800 + {6'd0, i_state.held}});

    // Text byte handling
    always_comb begin
        if (b == 8'h22) begin
            text_grp  = one_res(end_res(jsu_pkg::ST_CLOSE));
            text_mode = jsu_pkg::M_IDLE;
        end else if (b == 8'h5C) begin
            text_grp  = '0;
            text_mode = jsu_pkg::M_ESC;
        end else begin
            text_grp  = one_res(data_res(b));
            text_mode = jsu_pkg::M_TEXT;
        end
    end

    // Byte after a backslash
    always_comb begin
        esc_is_u = 1'b0;
        esc_mode = jsu_pkg::M_TEXT;
        unique case (b)
            8'h22:   esc_grp = one_res(data_res(8'h22));
            8'h5C:   esc_grp = one_res(data_res(8'h5C));
            8'h2F:   esc_grp = one_res(data_res(8'h2F));
            8'h62:   esc_grp = one_res(data_res(8'h08));
            8'h66:   esc_grp = one_res(data_res(8'h0C));
            8'h6E:   esc_grp = one_res(data_res(8'h0A));
            8'h72:   esc_grp = one_res(data_res(8'h0D));
            8'h74:   esc_grp = one_res(data_res(8'h09));
            8'h75: begin
                esc_grp  = '0;
                esc_is_u = 1'b1;
                esc_mode = jsu_pkg::M_HEX1;
            end
            default: begin
                esc_grp  = one_res(end_res(jsu_pkg::ST_BAD_ESC));
                esc_mode = jsu_pkg::M_IDLE;
            end
        endcase
    end

    always_comb begin
        ns       = i_state;
        main_grp = '0;
        lone     = 1'b0;
        if (i_input_ends) begin
            lone = (i_state.mode == jsu_pkg::M_HIGH) || (i_state.mode == jsu_pkg::M_HIGH_ESC);
            if (i_state.mode != jsu_pkg::M_IDLE) begin
                main_grp = one_res(end_res(jsu_pkg::ST_UNTERM));
            end
            ns.mode      = jsu_pkg::M_IDLE;
            ns.hex_count = 2'd0;
        end else begin
            unique case (i_state.mode)
                jsu_pkg::M_ESC: begin
                    main_grp = esc_grp;
                    ns.mode  = esc_mode;
                    if (esc_is_u) begin
                        ns.hex_accum = 16'h0000;
                        ns.hex_count = 2'd0;
                    end
                end
                jsu_pkg::M_HEX1, jsu_pkg::M_HEX2: begin
                    if (!hex_ok) begin
                        main_grp = one_res(end_res((i_state.mode == jsu_pkg::M_HEX1) ?
                                   jsu_pkg::ST_BAD_HEX : jsu_pkg::ST_BAD_PAIR));
                        ns.mode  = jsu_pkg::M_IDLE;
                    end else begin
                        ns.hex_accum = acc_new;
                        if (i_state.hex_count != 2'd3) begin
                            ns.hex_count = i_state.hex_count + 2'd1;
                        end else begin
                            ns.hex_count = 2'd0;
                            if (i_state.mode == jsu_pkg::M_HEX1) begin
                                if ((acc_new >= 16'hD800) && (acc_new <= 16'hDBFF)) begin
                                    ns.held = acc_new[9:0];
                                    ns.mode = jsu_pkg::M_HIGH;
                                end else begin
                                    main_grp = utf8({5'd0, acc_new});
                                    ns.mode  = jsu_pkg::M_TEXT;
                                end
                            end else if ((acc_new < 16'hDC00) || (acc_new > 16'hDFFF)) begin
                                main_grp = one_res(end_res(jsu_pkg::ST_BAD_PAIR));
                                ns.mode  = jsu_pkg::M_IDLE;
                            end else begin
                                main_grp = utf8(pair_cp);
                                ns.mode  = jsu_pkg::M_TEXT;
                            end
                        end
                    end
                end
                jsu_pkg::M_HIGH: begin
                    if (b == 8'h5C) begin
                        ns.mode = jsu_pkg::M_HIGH_ESC;
                    end else begin
                        lone     = 1'b1;
                        main_grp = text_grp;
                        ns.mode  = text_mode;
                    end
                end
                jsu_pkg::M_HIGH_ESC: begin
                    if (b == 8'h75) begin
                        ns.hex_accum = 16'h0000;
                        ns.hex_count = 2'd0;
                        ns.mode      = jsu_pkg::M_HEX2;
                    end else begin
                        lone     = 1'b1;
                        main_grp = esc_grp;
                        ns.mode  = esc_mode;
                        // any other escape: the held surrogate goes out as lone, then this escape is decoded normally
                        if (esc_is_u) begin
                            ns.hex_accum = 16'h0000;
                            ns.hex_count = 2'd0;
                        end
                    end
                end
                default: begin
                    main_grp = text_grp;
                    ns.mode  = text_mode;
                end
            endcase
        end
    end

    // Lone surrogate bytes go ahead of at most one further result
    always_comb begin
        if (lone) begin
            o_group.cnt    = 3'd3 + main_grp.cnt;
            o_group.res[0] = lone_grp.res[0];
            o_group.res[1] = lone_grp.res[1];
            o_group.res[2] = lone_grp.res[2];
            o_group.res[3] = main_grp.res[0];
        end else begin
            o_group = main_grp;
        end
    end

    assign o_next_state = ns;

endmodule

>>> rtl/json_string_unescape_core.sv
// JSON string unescaper. Feed the bytes of a string body after its opening quote, one per
// input transaction, or a transaction with input_ends set to mark end of input; each
// transaction yields zero to four result transactions (decoded bytes, then a closing or error
// status with last set). An input transaction is decoded in the cycle it is accepted into a
// four-entry result register that drains one result per cycle while the output is ready; the
// next input is accepted in the cycle that register empties or sends its final result.
module json_string_unescape_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    jsu_in_if.sink     i_in,
    jsu_out_if.source  o_out
);

    jsu_pkg::t_dec_state                 r_state;
    jsu_pkg::t_dec_state                 n_state;
    jsu_pkg::t_group                     dec_group;
    jsu_pkg::t_res [jsu_pkg::MAX_RES-1:0] r_res;
    logic [2:0]                          r_cnt;
    logic                                in_acc;
    logic                                out_acc;

    jsu_decoder u_dec (
        .i_state      (r_state),
        .i_raw_byte   (i_in.raw_byte),
        .i_input_ends (i_in.input_ends),
        .o_next_state (n_state),
        .o_group      (dec_group)
    );

    assign o_out.valid    = (r_cnt != 3'd0);
    assign o_out.out_byte = r_res[0].out_byte;
    assign o_out.status   = r_res[0].status;
    assign o_out.last     = r_res[0].last;
    assign out_acc        = o_out.valid && o_out.ready;

    assign i_in.ready = (r_cnt == 3'd0) || ((r_cnt == 3'd1) && o_out.ready);
    assign in_acc     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.mode      <= jsu_pkg::M_IDLE;
            r_state.hex_accum <= 16'h0000;
            r_state.hex_count <= 2'd0;
            r_state.held      <= 10'd0;
            r_cnt             <= 3'd0;
        end else if (in_acc) begin
            r_state <= n_state;
            r_cnt   <= dec_group.cnt;
        end else if (out_acc) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_res <= dec_group.res;
        end else if (out_acc) begin
            r_res[0] <= r_res[1];
            r_res[1] <= r_res[2];
            r_res[2] <= r_res[3];
        end
    end

    a_mode_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state.mode))
        else $error("decoder mode not one-hot");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4)
        else $error("result count overflow");

    a_last_is_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.last) |-> (r_cnt == 3'd1))
        else $error("closing result not final in its group");

    a_last_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.last == (o_out.status != jsu_pkg::ST_DATA)))
        else $error("last flag disagrees with status");

endmodule
